### src/brfr_pkg.sv
package brfr_pkg;

   // Widths of the command and result fields.
   localparam int OPCODE_W = 2;
   localparam int ARG_A_W = 7;
   localparam int ARG_B_W = 6;
   localparam int LIT_W = 10;
   localparam int ARG_B_N = 1 << ARG_B_W;
   localparam logic [LIT_W-1:0] LIT_MAX = '1;

   // Widest row the engine supports; row updates travel at this width.
   localparam int COLS_MAX = 64;
   localparam int GRP_W = 8;
   localparam int GRP_N = COLS_MAX / GRP_W;
   localparam int GRP_CNT_W = $clog2(GRP_W + 1);
   localparam int SUM_W = $clog2(COLS_MAX + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_FILL    = 2'd0,
      OP_ROT_ROW = 2'd1,
      OP_ROT_COL = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_FILL,
      MODE_ROT_ROW,
      MODE_GATHER,
      MODE_SCATTER
   } mode_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_PASS,
      SEQ_DRAIN,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      logic start;
      opcode_type opcode;
      logic [ARG_A_W-1:0] arg_a;
      logic [ARG_B_W-1:0] arg_b;
   } cmd_type;

   typedef struct packed {
      logic wr;
      logic [COLS_MAX-1:0] old_bits;
      logic [COLS_MAX-1:0] new_bits;
   } row_upd_type;

endpackage

### src/bitmap_rect_fill_rotate_engine.sv
// Bitmap engine: a ROWS x COLS one-bit-per-pixel image kept one row per word
// in a small synchronous memory. Each request transaction (req_opcode,
// req_arg_a, req_arg_b) fills the top-left rectangle, rotates one row right or
// rotates one column down; each produces exactly one response transaction
// carrying rsp_lit_count, the number of lit pixels afterwards (saturated at 1023).
// Both channels use valid/stall; a transaction completes when valid is high and
// stall is low. One command is worked on at a time: req_stall is high from
// acceptance until the response is loaded into the output register.
// A fill of height h reads and rewrites h rows, a row rotate one row, a column
// rotate passes over every row twice (one read pass to gather the column, one
// read-modify-write pass to put it back), and a command that changes nothing
// touches no row. The memory's single read and write port moves one row per
// cycle, and the lit count trails the writes by two pipeline stages. A response
// waiting under rsp_stall holds the output register, and the next request is
// still taken meanwhile; only its own result waits.
// Reset clears the image at once through per-row valid flags (no clearing pass)
// and zeroes the count.
module bitmap_rect_fill_rotate_engine #(
   parameter int ROWS = 8,
   parameter int COLS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [6:0]                   req_arg_a,
   input  logic [5:0]                   req_arg_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [9:0]                   rsp_lit_count
);

   import brfr_pkg::*;

   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LIT_W-1:0]   rsp_lit_count_ff, rsp_lit_count_in;
   logic               accept;
   logic               out_free;
   logic               seq_done;
   logic               count_idle;
   logic [LIT_W-1:0]   lit_count;
   cmd_type            cmd;
   row_upd_type        upd;
   logic               rd_en;
   logic [ROW_AW-1:0]  rd_addr;
   logic [COLS-1:0]    rd_data;
   logic               wr_en;
   logic [ROW_AW-1:0]  wr_addr;
   logic [COLS-1:0]    wr_data;

   // A request is taken only while no command is in flight.
   assign accept = req_valid && !busy_ff;
   assign req_stall = busy_ff;

   assign cmd.start = accept;
   assign cmd.opcode = opcode_type'(req_opcode);
   assign cmd.arg_a = req_arg_a;
   assign cmd.arg_b = req_arg_b;

   // The output register can take a new result when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   brfr_ram #(
      .WIDTH (COLS),
      .DEPTH (ROWS),
      .AW    (ROW_AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   brfr_seq #(
      .ROWS   (ROWS),
      .COLS   (COLS),
      .ROW_AW (ROW_AW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .out_free   (out_free),
      .count_idle (count_idle),
      .done       (seq_done),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .upd        (upd)
   );

   brfr_count #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .idle      (count_idle),
      .lit_count (lit_count)
   );

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (seq_done) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_lit_count_in = rsp_lit_count_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_lit_count_in = lit_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_lit_count_ff <= rsp_lit_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lit_count = rsp_lit_count_ff;

`ifndef NO_ASSERTIONS
   // A command can only finish while one is in flight.
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> busy_ff)
      else $error("command finished with no command in flight");

   // An accepted request keeps the input side closed in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> busy_ff)
      else $error("engine not busy after accepting a request");

   // A finished command never overwrites a response that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response register overwritten while stalled");
`endif

endmodule

### src/brfr_ram.sv
module brfr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/brfr_count.sv
module brfr_count #(
   parameter int ROWS = 8,
   parameter int COLS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  brfr_pkg::row_upd_type                  upd,
   output logic                                   idle,
   output logic [brfr_pkg::LIT_W-1:0]             lit_count
);

   import brfr_pkg::*;

   localparam int TOTAL_W = $clog2(ROWS * COLS + 1);

   logic                 v1_ff, v1_in;
   logic [COLS_MAX-1:0]  old_ff, new_ff;
   logic                 v2_ff, v2_in;
   logic [GRP_CNT_W-1:0] gain_grp_ff [GRP_N];
   logic [GRP_CNT_W-1:0] gain_grp_in [GRP_N];
   logic [GRP_CNT_W-1:0] lost_grp_ff [GRP_N];
   logic [GRP_CNT_W-1:0] lost_grp_in [GRP_N];
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [COLS_MAX-1:0]  gain_bits, lost_bits;
   logic [SUM_W-1:0]     gain_sum, lost_sum;
   logic [TOTAL_W+LIT_W-1:0] total_ext;

   // Stage two counts the pixels turned on and off in each group of eight.
   always_comb begin
      gain_bits = new_ff & ~old_ff;
      lost_bits = old_ff & ~new_ff;
      for (int g = 0; g < GRP_N; g++) begin
         gain_grp_in[g] = '0;
         lost_grp_in[g] = '0;
         for (int k = 0; k < GRP_W; k++) begin
            gain_grp_in[g] = gain_grp_in[g] + GRP_CNT_W'(gain_bits[g*GRP_W+k]);
            lost_grp_in[g] = lost_grp_in[g] + GRP_CNT_W'(lost_bits[g*GRP_W+k]);
         end
      end
   end

   // Stage three folds the group counts into the running total.
   always_comb begin
      gain_sum = '0;
      lost_sum = '0;
      for (int g = 0; g < GRP_N; g++) begin
         gain_sum = gain_sum + SUM_W'(gain_grp_ff[g]);
         lost_sum = lost_sum + SUM_W'(lost_grp_ff[g]);
      end
      total_in = total_ff;
      if (v2_ff) begin
         total_in = total_ff + TOTAL_W'(gain_sum) - TOTAL_W'(lost_sum);
      end
   end

   assign v1_in = upd.wr;
   assign v2_in = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      old_ff <= upd.old_bits;
      new_ff <= upd.new_bits;
      gain_grp_ff <= gain_grp_in;
      lost_grp_ff <= lost_grp_in;
   end

   assign idle = !v1_ff && !v2_ff;
   assign total_ext = (TOTAL_W + LIT_W)'(total_ff);
   assign lit_count = (total_ext > (TOTAL_W + LIT_W)'(LIT_MAX)) ? LIT_MAX
                                                                 : total_ext[LIT_W-1:0];

endmodule

### src/brfr_seq.sv
module brfr_seq #(
   parameter int ROWS = 8,
   parameter int COLS = 64,
   parameter int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  brfr_pkg::cmd_type     cmd,
   input  logic                  out_free,
   input  logic                  count_idle,
   output logic                  done,
   output logic                  rd_en,
   output logic [ROW_AW-1:0]     rd_addr,
   input  logic [COLS-1:0]       rd_data,
   output logic                  wr_en,
   output logic [ROW_AW-1:0]     wr_addr,
   output logic [COLS-1:0]       wr_data,
   output brfr_pkg::row_upd_type upd
);

   import brfr_pkg::*;

   localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;

   seq_state_type       state_ff, state_in;
   mode_type            mode_ff, mode_in;
   logic [ROW_AW-1:0]   iss_ff, iss_in;
   logic [ROW_AW-1:0]   last_ff, last_in;
   logic                pend_ff, pend_in;
   logic [ROW_AW-1:0]   pend_row_ff, pend_row_in;
   logic [COLS-1:0]     mask_ff, mask_in;
   logic [COL_AW-1:0]   sh_ff, sh_in;
   logic [COL_AW-1:0]   col_ff, col_in;
   logic [ROW_AW-1:0]   src_ff, src_in;
   logic [ROWS-1:0]     bits_ff, bits_in;
   logic [ROWS-1:0]     row_valid_ff, row_valid_in;

   logic [ROW_AW-1:0]   rows_mod [ARG_B_N];
   logic [COL_AW-1:0]   cols_mod [ARG_B_N];

   logic [ARG_A_W-1:0]  w_sat, h_sat;
   logic [COLS-1:0]     mask_new;
   logic                a_row_ok, a_col_ok;
   logic [COL_AW-1:0]   s_row;
   logic [ROW_AW-1:0]   s_col;
   logic [COLS-1:0]     old_row, new_row;
   logic [2*COLS-1:0]   dbl;

   // Rotation amounts reduced modulo the row and column lengths.
   for (genvar g = 0; g < ARG_B_N; g++) begin : g_mod
      assign rows_mod[g] = ROW_AW'(g % ROWS);
      assign cols_mod[g] = COL_AW'(g % COLS);
   end

   always_comb begin
      w_sat = (cmd.arg_a > ARG_A_W'(COLS)) ? ARG_A_W'(COLS) : cmd.arg_a;
      h_sat = ({1'b0, cmd.arg_b} > ARG_A_W'(ROWS)) ? ARG_A_W'(ROWS) : {1'b0, cmd.arg_b};
      for (int j = 0; j < COLS; j++) begin
         mask_new[j] = ARG_A_W'(j) < w_sat;
      end
      a_row_ok = cmd.arg_a < ARG_A_W'(ROWS);
      a_col_ok = cmd.arg_a < ARG_A_W'(COLS);
      s_row = cols_mod[cmd.arg_b];
      s_col = rows_mod[cmd.arg_b];
   end

   // Sequencer: walks the rows of one pass, two passes for a column rotate.
   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      iss_in = iss_ff;
      last_in = last_ff;
      mask_in = mask_ff;
      sh_in = sh_ff;
      col_in = col_ff;
      rd_en = 1'b0;
      done = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (cmd.start) begin
               unique case (cmd.opcode)
                  OP_FILL: begin
                     mode_in = MODE_FILL;
                     mask_in = mask_new;
                     iss_in = '0;
                     last_in = ROW_AW'(h_sat - ARG_A_W'(1));
                     state_in = (h_sat != '0 && w_sat != '0) ? SEQ_PASS : SEQ_FINISH;
                  end
                  OP_ROT_ROW: begin
                     mode_in = MODE_ROT_ROW;
                     sh_in = s_row;
                     iss_in = ROW_AW'(cmd.arg_a);
                     last_in = ROW_AW'(cmd.arg_a);
                     state_in = (a_row_ok && s_row != '0) ? SEQ_PASS : SEQ_FINISH;
                  end
                  OP_ROT_COL: begin
                     mode_in = MODE_GATHER;
                     col_in = COL_AW'(cmd.arg_a);
                     iss_in = '0;
                     last_in = ROW_AW'(ROWS - 1);
                     state_in = (a_col_ok && s_col != '0) ? SEQ_PASS : SEQ_FINISH;
                  end
                  OP_NONE: begin
                     state_in = SEQ_FINISH;
                  end
               endcase
            end
         end
         SEQ_PASS: begin
            rd_en = 1'b1;
            if (iss_ff == last_ff) begin
               state_in = SEQ_DRAIN;
            end else begin
               iss_in = iss_ff + ROW_AW'(1);
            end
         end
         SEQ_DRAIN: begin
            if (mode_ff == MODE_GATHER) begin
               mode_in = MODE_SCATTER;
               iss_in = '0;
               state_in = SEQ_PASS;
            end else begin
               state_in = SEQ_FINISH;
            end
         end
         SEQ_FINISH: begin
            if (count_idle && out_free) begin
               done = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
      endcase
   end

   assign rd_addr = iss_ff;
   assign pend_in = rd_en;
   assign pend_row_in = iss_ff;

   // Row modify stage: works on the row read in the previous cycle.
   always_comb begin
      old_row = row_valid_ff[pend_row_ff] ? rd_data : '0;
      dbl = {old_row, old_row} << sh_ff;
      new_row = old_row;
      wr_en = 1'b0;
      bits_in = bits_ff;
      src_in = src_ff;
      if (state_ff == SEQ_IDLE && cmd.start) begin
         src_in = (s_col == '0) ? '0 : ROW_AW'(ROWS) - s_col;
      end
      if (pend_ff) begin
         case (mode_ff)
            MODE_FILL: begin
               new_row = old_row | mask_ff;
               wr_en = 1'b1;
            end
            MODE_ROT_ROW: begin
               new_row = dbl[2*COLS-1:COLS];
               wr_en = 1'b1;
            end
            MODE_GATHER: begin
               bits_in[pend_row_ff] = old_row[col_ff];
            end
            MODE_SCATTER: begin
               new_row[col_ff] = bits_ff[src_ff];
               wr_en = 1'b1;
               src_in = (src_ff == ROW_AW'(ROWS - 1)) ? '0 : src_ff + ROW_AW'(1);
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[pend_row_ff] = 1'b1;
      end
   end

   assign wr_addr = pend_row_ff;
   assign wr_data = new_row;
   assign upd.wr = wr_en;
   assign upd.old_bits = COLS_MAX'(old_row);
   assign upd.new_bits = COLS_MAX'(new_row);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pend_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      iss_ff <= iss_in;
      last_ff <= last_in;
      pend_row_ff <= pend_row_in;
      mask_ff <= mask_in;
      sh_ff <= sh_in;
      col_ff <= col_in;
      src_ff <= src_in;
      bits_ff <= bits_in;
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

import brfr_pkg::*;

// Tracks the image the engine should hold and the lit counts it owes.
class lit_count_board;
   logic [63:0] pixel_rows [8];
   logic [9:0]  owed_counts [$];
   int          errors;
   int          counts_checked;
   int          ops_seen [4];

   function new();
      foreach (pixel_rows[i]) pixel_rows[i] = '0;
      errors = 0;
      counts_checked = 0;
      foreach (ops_seen[i]) ops_seen[i] = 0;
   endfunction

   // Applies one accepted command to the image and queues the count it leaves.
   function void note_command(opcode_type op, logic [6:0] a, logic [5:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned s;
      int unsigned total;
      logic [63:0] v;
      logic [7:0]  col_bits;
      logic [9:0]  owed;

      ops_seen[op]++;
      case (op)
         OP_FILL: begin
            w = (a > 7'd64) ? 32'd64 : 32'(a);
            h = (b > 6'd8) ? 32'd8 : 32'(b);
            v = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
            for (int i = 0; i < h; i++) pixel_rows[i] |= v;
         end
         OP_ROT_ROW: begin
            s = 32'(b) % 64;
            if (a < 7'd8 && s != 0) begin
               v = pixel_rows[a[2:0]];
               pixel_rows[a[2:0]] = (v << s) | (v >> (64 - s));
            end
         end
         OP_ROT_COL: begin
            s = 32'(b) % 8;
            if (a < 7'd64 && s != 0) begin
               for (int i = 0; i < 8; i++) col_bits[i] = pixel_rows[i][a[5:0]];
               for (int i = 0; i < 8; i++)
                  pixel_rows[i][a[5:0]] = col_bits[3'((i + 8 - s) % 8)];
            end
         end
         default: begin
         end
      endcase

      total = 0;
      foreach (pixel_rows[i]) total += $countones(pixel_rows[i]);
      owed = (total > 1023) ? 10'd1023 : total[9:0];
      owed_counts = {owed_counts, owed};
   endfunction

   // Compares one response with the oldest count still owed.
   function void check_count(logic [9:0] actual);
      logic [9:0] expected;

      if (owed_counts.size() == 0) begin
         $display("%0t: unexpected response transaction, lit count %0d", $time, actual);
         errors++;
      end else begin
         expected = owed_counts.pop_front();
         counts_checked++;
         if (actual !== expected) begin
            $display("%0t: lit count mismatch, expected %0d actual %0d",
                     $time, expected, actual);
            errors++;
         end
      end
   endfunction

   function int pending();
      return owed_counts.size();
   endfunction
endclass

module testbench;

   localparam int ROWS = 8;
   localparam int COLS = 64;

   // The sender offers this many random commands after the directed ones.
   localparam int RANDOM_ITEMS = 1020;
   // A stretch this long with no handshake on either side ends the run.
   localparam int WATCHDOG_LIMIT = 2000;
   // The receiver holds its stall high this long once, so the engine fills up.
   localparam int LONG_HOLD_CYCLES = 300;
   // Cycles allowed for trailing activity after the last response; the slowest
   // command is a column rotate.
   localparam int DRAIN_CYCLES = 2 * ROWS + 20;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_opcode;
   logic [6:0] req_arg_a;
   logic [5:0] req_arg_b;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [9:0] rsp_lit_count;

   // Set by the sequence to ask for one long hold-off on the response side.
   bit hold_output;
   // While set, neither side idles, so transactions run back to back.
   bit steady;

   lit_count_board board;

   bitmap_rect_fill_rotate_engine #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_arg_a    (req_arg_a),
      .req_arg_b    (req_arg_b),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_lit_count(rsp_lit_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Both monitors sample at the rising edge, where every input was set up at
   // the falling edge before. A request is noted before a response is checked,
   // although a response can never belong to the request taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_command(opcode_type'(req_opcode), req_arg_a, req_arg_b);
         if (rsp_valid && !rsp_stall)
            board.check_count(rsp_lit_count);
      end
   end

   // The watchdog counts cycles with no transaction on either channel. The
   // longest quiet stretch in a correct run is the long receiver hold-off.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no transaction for %0d cycles, %0d lit counts still owed",
               $time, WATCHDOG_LIMIT, board.pending());
      $display("RESULT: ERROR");
      $finish;
   end

   // Response side. Stall comes in runs: mostly short stalls between longer
   // open stretches, now and then a long stall, and once a very long hold-off
   // that is counted here so the sender keeps offering commands meanwhile.
   initial begin : receiver
      int pick;
      int run_len;
      rsp_stall = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end else if (steady) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               rsp_stall <= 1'b0;
               run_len = $urandom_range(1, 20);
            end else if (pick < 90) begin
               rsp_stall <= 1'b1;
               run_len = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               run_len = $urandom_range(10, 40);
            end
            repeat (run_len) @(negedge clock);
         end
      end
   end

   // Gap the sender leaves after a transaction: usually none or a few cycles,
   // sometimes a long one.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one command and holds it steady until the engine takes it. With a
   // gap of zero the next call raises valid again at the very next falling
   // edge, so valid simply stays high across back-to-back transactions.
   task automatic send_command(opcode_type op, logic [6:0] a, logic [5:0] b);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_arg_a  <= a;
      req_arg_b  <= b;
      do @(posedge clock); while (!(req_valid && !req_stall));
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Lowers valid and waits until every owed lit count has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Random commands are mostly rotations with in-range indices, since a fill
   // only ever adds pixels and the image would light up completely. Fills are
   // mostly small; a few are oversized in one direction or both. Out-of-range
   // indices and the unused opcode make up the rest.
   task automatic send_random_command();
      int          pick;
      opcode_type  op;
      logic [6:0]  a;
      logic [5:0]  b;
      pick = $urandom_range(0, 99);
      b = 6'($urandom_range(0, 63));
      if (pick < 14) begin
         op = OP_FILL;
         case ($urandom_range(0, 19))
            0: begin
               a = 7'($urandom_range(0, 127));
               b = 6'($urandom_range(0, 1));
            end
            1: begin
               a = 7'($urandom_range(0, 2));
               b = 6'($urandom_range(0, 63));
            end
            2: begin
               a = 7'($urandom_range(0, 127));
               b = 6'($urandom_range(0, 63));
            end
            default: begin
               a = 7'($urandom_range(0, 7));
               b = 6'($urandom_range(0, 3));
            end
         endcase
      end else if (pick < 52) begin
         op = OP_ROT_ROW;
         a = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, ROWS - 1))
                                          : 7'($urandom_range(0, 127));
      end else if (pick < 92) begin
         op = OP_ROT_COL;
         a = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, COLS - 1))
                                          : 7'($urandom_range(0, 127));
      end else begin
         op = OP_NONE;
         a = 7'($urandom_range(0, 127));
      end
      send_command(op, a, b);
   endtask

   initial begin : sequence_main
      board       = new();
      hold_output = 1'b0;
      steady      = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = OP_NONE;
      req_arg_a   = '0;
      req_arg_b   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Empty rectangles first, then a small one that the
      // rotations below can move around.
      send_command(OP_FILL, 7'd0, 6'd0);
      send_command(OP_FILL, 7'd0, 6'd5);
      send_command(OP_FILL, 7'd5, 6'd0);
      send_command(OP_FILL, 7'd3, 6'd2);
      // Row rotations: by one, by the largest amount, by zero, and by 17 on the
      // last row. Then rows out of range.
      send_command(OP_ROT_ROW, 7'd0, 6'd1);
      send_command(OP_ROT_ROW, 7'd1, 6'd63);
      send_command(OP_ROT_ROW, 7'd0, 6'd0);
      send_command(OP_ROT_ROW, 7'd7, 6'd17);
      send_command(OP_ROT_ROW, 7'd8, 6'd5);
      send_command(OP_ROT_ROW, 7'd127, 6'd1);
      // Column rotations, including amounts above the column length, the last
      // column and indices out of range.
      send_command(OP_ROT_COL, 7'd0, 6'd1);
      send_command(OP_ROT_COL, 7'd2, 6'd7);
      send_command(OP_ROT_COL, 7'd1, 6'd8);
      send_command(OP_ROT_COL, 7'd63, 6'd63);
      send_command(OP_ROT_COL, 7'd64, 6'd3);
      send_command(OP_ROT_COL, 7'd127, 6'd2);
      // Unused opcode with every argument bit set.
      send_command(OP_NONE, 7'd127, 6'd63);
      // Oversized in one direction only: a full top row and a full left column.
      send_command(OP_FILL, 7'd127, 6'd1);
      send_command(OP_FILL, 7'd1, 6'd63);
      send_command(OP_ROT_ROW, 7'd0, 6'd32);
      send_command(OP_ROT_COL, 7'd40, 6'd4);

      // Random part with the pressure phases spread through it.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) hold_output = 1'b1;
         if (n == 600) wait_for_drain();
         steady = (n >= 700 && n < 800);
         send_random_command();
      end

      // Saturating rectangles come last, since afterwards every pixel is lit.
      send_command(OP_FILL, 7'd64, 6'd8);
      send_command(OP_ROT_ROW, 7'd3, 6'd9);
      send_command(OP_FILL, 7'd127, 6'd63);
      send_command(OP_ROT_COL, 7'd5, 6'd3);
      send_command(OP_NONE, 7'd0, 6'd0);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d fills, %0d row rotates, %0d column rotates and %0d unused opcodes;",
               board.ops_seen[OP_FILL], board.ops_seen[OP_ROT_ROW],
               board.ops_seen[OP_ROT_COL], board.ops_seen[OP_NONE]);
      $display("%0d lit counts compared, with one long response hold-off and one full drain.",
               board.counts_checked);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### bitmap_rect_fill_rotate_engine.f
src/brfr_pkg.sv
src/brfr_ram.sv
src/brfr_count.sv
src/brfr_seq.sv
src/bitmap_rect_fill_rotate_engine.sv
tb/testbench.sv
